// ===== src/triangle_edge_function_rasterizer_unit_macros.svh =====
// assertion macros for the triangle rasterizer
// used by the top level only, no other dependencies
`ifndef TRIANGLE_EDGE_FUNCTION_RASTERIZER_UNIT_MACROS_SVH
`define TRIANGLE_EDGE_FUNCTION_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TEFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TEFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tefr_pkg.sv =====
// shared types and constants of the triangle rasterizer
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package tefr_pkg;

  // grid size defaults
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // field and register widths
  localparam int XW        = 32;
  localparam int CW_W      = 31;
  localparam int NUSE_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int RC_W      = 6;
  localparam int OCNT_W    = 13;
  localparam int DIM_W     = 11;   // holds a grid dimension up to 2047

  // edge arithmetic widths
  localparam int EW     = 82;      // edge function, units of 2^-34
  localparam int PW     = 47;      // 4x scaled sample coordinate
  localparam int MA_W   = 33;      // multiplier a operand magnitude
  localparam int MB_W   = 48;      // multiplier b operand magnitude
  localparam int DIG_W  = 16;      // b digit per cycle
  localparam int NDIG   = 3;
  localparam int MUL_N  = 14;      // products per triangle setup
  localparam int DIV_N  = 4;       // divisions per triangle setup

  localparam logic [XW-1:0] EMPTY_DEPTH = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] EDGE_TOL    = EW'(17180);

  // configuration register reset values
  localparam logic [CW_W-1:0]   RST_CELL_SIZE = 31'd65536;
  localparam logic [NUSE_W-1:0] RST_IN_USE    = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CELL_WIDTH  = 3'd2,
    REG_CELL_HEIGHT = 3'd3,
    REG_COLS_IN_USE = 3'd4,
    REG_ROWS_IN_USE = 3'd5
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_run;
    logic rd_en;
    logic div_run;
    logic mul_run;
    logic walk_run;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic mul_last;
    logic walk_last;
    logic out_free;
  } st_t;

endpackage

// ===== src/tefr_ctrl.sv =====
// controller state machine of the triangle rasterizer
// depends on tefr_pkg; drives commands into tefr_dp
`timescale 1ns / 1ps

module tefr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           mode_i,
  output logic           in_stall_o,
  input  tefr_pkg::st_t  st_i,
  output tefr_pkg::cmd_t cmd_o
);
  import tefr_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = mode_i ? S_READ : S_DIV;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_FIN;
      end
      S_DIV: begin
        cmd_o.div_run = 1'b1;
        if (st_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_run = 1'b1;
        if (st_i.mul_last) state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_run = 1'b1;
        if (st_i.walk_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register, clearing pass first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== src/tefr_dp.sv =====
// datapath of the triangle rasterizer: config, divider, multiplier, walk, grid memory
// depends on tefr_pkg; sequenced by tefr_ctrl
`timescale 1ns / 1ps

module tefr_dp #(
  parameter int MAX_ROWS = tefr_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tefr_pkg::DEF_MAX_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tefr_pkg::cmd_t                  cmd_i,
  output tefr_pkg::st_t                   st_o,
  input  logic                            cfg_we_i,
  input  logic [tefr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tefr_pkg::XW-1:0]         cfg_data_i,
  input  logic                            mode_i,
  input  logic signed [tefr_pkg::XW-1:0]  ax_i,
  input  logic signed [tefr_pkg::XW-1:0]  ay_i,
  input  logic signed [tefr_pkg::XW-1:0]  az_i,
  input  logic signed [tefr_pkg::XW-1:0]  bx_i,
  input  logic signed [tefr_pkg::XW-1:0]  by_coord_i,
  input  logic signed [tefr_pkg::XW-1:0]  bz_i,
  input  logic signed [tefr_pkg::XW-1:0]  cx_i,
  input  logic signed [tefr_pkg::XW-1:0]  cy_i,
  input  logic signed [tefr_pkg::XW-1:0]  cz_i,
  input  logic [tefr_pkg::RC_W-1:0]       read_col_i,
  input  logic [tefr_pkg::RC_W-1:0]       read_row_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic signed [tefr_pkg::XW-1:0]  depth_value_o,
  output logic                            cell_empty_o,
  output logic [tefr_pkg::OCNT_W-1:0]     cells_written_o
);
  import tefr_pkg::*;

  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int MemW  = XW + 1;
  localparam logic [DIM_W-1:0] ColsN  = DIM_W'(MAX_COLS);
  localparam logic [DIM_W-1:0] RowsN  = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] ColMax = DIM_W'(MAX_COLS - 1);
  localparam logic [DIM_W-1:0] RowMax = DIM_W'(MAX_ROWS - 1);
  localparam logic [3:0] P_PX = 4'd0;
  localparam logic [3:0] P_PY = 4'd1;
  localparam logic [5:0] DivEnd = 6'd33;
  localparam logic [2:0] MulEnd = 3'(NDIG + 1);

  typedef enum logic [1:0] {
    TERM_T1 = 2'd0,
    TERM_T2 = 2'd1,
    TERM_SX = 2'd2,
    TERM_SY = 2'd3
  } term_e;

  function automatic logic [XW-1:0] smin(input logic [XW-1:0] a, input logic [XW-1:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [XW-1:0] smax(input logic [XW-1:0] a, input logic [XW-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  // configuration registers
  logic [XW-1:0]     origin_x_q, origin_y_q;
  logic [CW_W-1:0]   cell_width_q, cell_height_q;
  logic [NUSE_W-1:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      cell_width_q  <= RST_CELL_SIZE;
      cell_height_q <= RST_CELL_SIZE;
      cols_q        <= RST_IN_USE;
      rows_q        <= RST_IN_USE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X:    origin_x_q    <= cfg_data_i;
        REG_ORIGIN_Y:    origin_y_q    <= cfg_data_i;
        REG_CELL_WIDTH:  cell_width_q  <= cfg_data_i[CW_W-1:0];
        REG_CELL_HEIGHT: cell_height_q <= cfg_data_i[CW_W-1:0];
        REG_COLS_IN_USE: cols_q        <= cfg_data_i[NUSE_W-1:0];
        REG_ROWS_IN_USE: rows_q        <= cfg_data_i[NUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective cell size and grid extent
  logic [CW_W-1:0]  cw_eff, ch_eff;
  logic [DIM_W-1:0] cols_ext, rows_ext, ncol, nrow;

  always_comb begin
    cw_eff   = (cell_width_q == '0) ? CW_W'(1) : cell_width_q;
    ch_eff   = (cell_height_q == '0) ? CW_W'(1) : cell_height_q;
    cols_ext = DIM_W'(cols_q);
    rows_ext = DIM_W'(rows_q);
    ncol = (cols_ext == '0) ? DIM_W'(1) : ((cols_ext > ColsN) ? ColsN : cols_ext);
    nrow = (rows_ext == '0) ? DIM_W'(1) : ((rows_ext > RowsN) ? RowsN : rows_ext);
  end

  // item capture
  logic          mode_q;
  logic [XW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, zmin_q;
  logic [XW-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic [AW-1:0] rd_addr_q;
  logic [DIM_W-1:0] rcol_c, rrow_c;

  always_comb begin
    rcol_c = (DIM_W'(read_col_i) > ColMax) ? ColMax : DIM_W'(read_col_i);
    rrow_c = (DIM_W'(read_row_i) > RowMax) ? RowMax : DIM_W'(read_row_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q    <= mode_i;
      x0_q      <= ax_i;
      y0_q      <= ay_i;
      x1_q      <= bx_i;
      y1_q      <= by_coord_i;
      x2_q      <= cx_i;
      y2_q      <= cy_i;
      zmin_q    <= smin(smin(az_i, bz_i), cz_i);
      xmin_q    <= smin(smin(ax_i, bx_i), cx_i);
      xmax_q    <= smax(smax(ax_i, bx_i), cx_i);
      ymin_q    <= smin(smin(ay_i, by_coord_i), cy_i);
      ymax_q    <= smax(smax(ay_i, by_coord_i), cy_i);
      rd_addr_q <= AW'(32'(rrow_c) * 32'(MAX_COLS) + 32'(rcol_c));
    end
  end

  // serial divider for the bounding box cell indices, one quotient bit a cycle
  logic [1:0]       op_q;
  logic [5:0]       dcnt_q;
  logic [XW-1:0]    quo_q;
  logic [CW_W-1:0]  rem_q;
  logic             dneg_q;
  logic [XW:0]      dvd_diff;
  logic [CW_W-1:0]  dvs;
  logic [XW-1:0]    r_sh;
  logic             r_ge;
  logic [DIM_W-1:0] lim, q_cl;
  logic [ColW-1:0]  c0_q, c1_q;
  logic [RowW-1:0]  r0_q, r1_q;

  always_comb begin
    logic [XW-1:0] v, o;
    v = xmin_q;
    o = origin_x_q;
    unique case (op_q)
      2'd0: begin v = xmin_q; o = origin_x_q; end
      2'd1: begin v = xmax_q; o = origin_x_q; end
      2'd2: begin v = ymin_q; o = origin_y_q; end
      2'd3: begin v = ymax_q; o = origin_y_q; end
      default: ;
    endcase
    dvd_diff = {v[XW-1], v} - {o[XW-1], o};
    dvs      = op_q[1] ? ch_eff : cw_eff;
    lim      = op_q[1] ? (nrow - DIM_W'(1)) : (ncol - DIM_W'(1));
    r_sh     = {rem_q, quo_q[XW-1]};
    r_ge     = (r_sh >= {1'b0, dvs});
    q_cl     = dneg_q ? '0 : ((quo_q > XW'(lim)) ? lim : quo_q[DIM_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.capture) begin
      op_q   <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_run) begin
      if (dcnt_q == DivEnd) begin
        dcnt_q <= '0;
        op_q   <= op_q + 2'd1;
      end else begin
        dcnt_q <= dcnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_run) begin
      if (dcnt_q == '0) begin
        quo_q  <= dvd_diff[XW-1:0];
        rem_q  <= '0;
        dneg_q <= dvd_diff[XW];
      end else if (dcnt_q == DivEnd) begin
        unique case (op_q)
          2'd0: c0_q <= ColW'(q_cl);
          2'd1: c1_q <= ColW'(q_cl);
          2'd2: r0_q <= RowW'(q_cl);
          2'd3: r1_q <= RowW'(q_cl);
          default: ;
        endcase
      end else begin
        rem_q <= r_ge ? CW_W'(r_sh - {1'b0, dvs}) : CW_W'(r_sh);
        quo_q <= {quo_q[XW-2:0], r_ge};
      end
    end
  end

  // digit-serial multiplier for the edge setup products
  logic [3:0]    p_q, pm2;
  logic [2:0]    mcnt_q;
  logic [EW-1:0] acc_q, prod;
  logic [MA_W-1:0] ma_q, ma_mag;
  logic [MB_W-1:0] mb_q;
  logic [PW-1:0]   mb_mag;
  logic            mneg_q;
  logic [MA_W+DIG_W-1:0] pp;
  logic [1:0]      ek;
  term_e           term;
  logic [XW-1:0]   xa, ya, xb, yb;
  logic [MA_W-1:0] dx, dy, sa;
  logic [PW-1:0]   ux, uy, sb, ox4, oy4;
  logic [PW-1:0]   px4_q, py4_q;
  logic [EW-1:0]   t1_q;
  logic [EW-1:0]   ecur_q [3];
  logic [EW-1:0]   erow_q [3];
  logic [EW-1:0]   sx_q [3];
  logic [EW-1:0]   sy_q [3];

  always_comb begin
    pm2    = p_q - 4'd2;
    ek     = pm2[3:2];
    term   = term_e'(pm2[1:0]);
    xa = x0_q; ya = y0_q; xb = x1_q; yb = y1_q;
    unique case (ek)
      2'd0:    begin xa = x0_q; ya = y0_q; xb = x1_q; yb = y1_q; end
      2'd1:    begin xa = x1_q; ya = y1_q; xb = x2_q; yb = y2_q; end
      default: begin xa = x2_q; ya = y2_q; xb = x0_q; yb = y0_q; end
    endcase
    dx  = {xb[XW-1], xb} - {xa[XW-1], xa};
    dy  = {yb[XW-1], yb} - {ya[XW-1], ya};
    ox4 = {{(PW-XW-2){origin_x_q[XW-1]}}, origin_x_q, 2'b00};
    oy4 = {{(PW-XW-2){origin_y_q[XW-1]}}, origin_y_q, 2'b00};
    ux  = px4_q - {{(PW-XW-2){xa[XW-1]}}, xa, 2'b00};
    uy  = py4_q - {{(PW-XW-2){ya[XW-1]}}, ya, 2'b00};
    // operand pair of the current product
    if (p_q == P_PX) begin
      sa = MA_W'({c0_q, 2'b01});
      sb = PW'(cw_eff);
    end else if (p_q == P_PY) begin
      sa = MA_W'({r0_q, 2'b01});
      sb = PW'(ch_eff);
    end else begin
      unique case (term)
        TERM_T1: begin sa = dx; sb = uy; end
        TERM_T2: begin sa = dy; sb = ux; end
        TERM_SX: begin sa = dy; sb = PW'({cw_eff, 2'b00}); end
        TERM_SY: begin sa = dx; sb = PW'({ch_eff, 2'b00}); end
        default: begin sa = dx; sb = uy; end
      endcase
    end
    ma_mag = sa[MA_W-1] ? (~sa + MA_W'(1)) : sa;
    mb_mag = sb[PW-1] ? (~sb + PW'(1)) : sb;
    pp     = ma_q * mb_q[MB_W-1 -: DIG_W];
    prod   = mneg_q ? (~acc_q + EW'(1)) : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.capture) begin
      p_q    <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.mul_run) begin
      if (mcnt_q == MulEnd) begin
        mcnt_q <= '0;
        p_q    <= p_q + 4'd1;
      end else begin
        mcnt_q <= mcnt_q + 3'd1;
      end
    end
  end

  // walk position and covered-cell count
  logic [ColW-1:0]   c_q;
  logic [RowW-1:0]   r_q;
  logic [OCNT_W-1:0] count_q;
  logic              covered, row_end, walk_last, mul_last;
  logic [AW-1:0]     walk_addr;

  assign covered   = ~ecur_q[0][EW-1] & ~ecur_q[1][EW-1] & ~ecur_q[2][EW-1];
  assign row_end   = (c_q == c1_q);
  assign walk_last = cmd_i.walk_run && row_end && (r_q == r1_q);
  assign mul_last  = cmd_i.mul_run && (p_q == 4'(MUL_N - 1)) && (mcnt_q == MulEnd);
  assign walk_addr = AW'(32'(r_q) * 32'(MAX_COLS) + 32'(c_q));

  // multiplier operands, product stores and incremental edge stepping
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_run) begin
      if (mcnt_q == '0) begin
        acc_q  <= '0;
        ma_q   <= ma_mag;
        mb_q   <= MB_W'(mb_mag);
        mneg_q <= sa[MA_W-1] ^ sb[PW-1];
      end else if (mcnt_q == MulEnd) begin
        if (p_q == P_PX) begin
          px4_q <= ox4 + prod[PW-1:0];
        end else if (p_q == P_PY) begin
          py4_q <= oy4 + prod[PW-1:0];
        end else begin
          unique case (term)
            TERM_T1: t1_q <= prod;
            TERM_T2: begin
              ecur_q[ek] <= t1_q - prod + EDGE_TOL;
              erow_q[ek] <= t1_q - prod + EDGE_TOL;
            end
            TERM_SX: sx_q[ek] <= ~prod + EW'(1);
            TERM_SY: sy_q[ek] <= prod;
            default: ;
          endcase
        end
      end else begin
        acc_q <= {acc_q[EW-DIG_W-1:0], {DIG_W{1'b0}}} + EW'(pp);
        mb_q  <= {mb_q[MB_W-DIG_W-1:0], {DIG_W{1'b0}}};
      end
    end else if (cmd_i.walk_run && !walk_last) begin
      for (int k = 0; k < 3; k++) begin
        if (row_end) begin
          erow_q[k] <= erow_q[k] + sy_q[k];
          ecur_q[k] <= erow_q[k] + sy_q[k];
        end else begin
          ecur_q[k] <= ecur_q[k] + sx_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_last) begin
      c_q <= c0_q;
      r_q <= r0_q;
    end else if (cmd_i.walk_run && !walk_last) begin
      if (row_end) begin
        c_q <= c0_q;
        r_q <= r_q + RowW'(1);
      end else begin
        c_q <= c_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.capture) begin
      count_q <= '0;
    end else if (cmd_i.walk_run && covered) begin
      count_q <= count_q + OCNT_W'(1);
    end
  end

  // clearing pass address
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_run) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // depth grid: written mark on top of the depth word
  logic [MemW-1:0] grid_mem [Depth];
  logic [MemW-1:0] rdata_q, wdata;
  logic [AW-1:0]   waddr;
  logic            mem_we;

  always_comb begin
    mem_we = cmd_i.clr_run || (cmd_i.walk_run && covered);
    waddr  = cmd_i.clr_run ? clr_addr_q : walk_addr;
    wdata  = cmd_i.clr_run ? {1'b0, EMPTY_DEPTH} : {1'b1, zmin_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= grid_mem[rd_addr_q];
    end
  end

  // result register
  logic              out_valid_q;
  logic [XW-1:0]     depth_q;
  logic              empty_q;
  logic [OCNT_W-1:0] cnt_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      depth_q   <= mode_q ? rdata_q[XW-1:0] : '0;
      empty_q   <= mode_q ? ~rdata_q[XW] : 1'b0;
      cnt_out_q <= mode_q ? '0 : count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign depth_value_o   = depth_q;
  assign cell_empty_o    = empty_q;
  assign cells_written_o = cnt_out_q;

  // status back to the controller
  always_comb begin
    st_o.clr_last  = cmd_i.clr_run && (clr_addr_q == AW'(Depth - 1));
    st_o.div_last  = cmd_i.div_run && (op_q == 2'(DIV_N - 1)) && (dcnt_q == DivEnd);
    st_o.mul_last  = mul_last;
    st_o.walk_last = walk_last;
    st_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== src/triangle_edge_function_rasterizer_unit.sv =====
// Read request: the grid is read in S_READ, then the result register is loaded in S_FIN once free.
// Triangle request: a setup of 4 divisions and 14 products, then the walk visits one box cell per cycle.
// Throughput: one request at a time; the serial divider and multiplier set the setup.
// Reset: a clearing pass over all MAX_ROWS*MAX_COLS cells (4096 by default) empties the grid
// before the first request is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps

`include "triangle_edge_function_rasterizer_unit_macros.svh"

module triangle_edge_function_rasterizer_unit #(
  parameter int MAX_ROWS = tefr_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tefr_pkg::DEF_MAX_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tefr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tefr_pkg::XW-1:0]         cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic signed [tefr_pkg::XW-1:0]  ax_i,
  input  logic signed [tefr_pkg::XW-1:0]  ay_i,
  input  logic signed [tefr_pkg::XW-1:0]  az_i,
  input  logic signed [tefr_pkg::XW-1:0]  bx_i,
  input  logic signed [tefr_pkg::XW-1:0]  by_coord_i,
  input  logic signed [tefr_pkg::XW-1:0]  bz_i,
  input  logic signed [tefr_pkg::XW-1:0]  cx_i,
  input  logic signed [tefr_pkg::XW-1:0]  cy_i,
  input  logic signed [tefr_pkg::XW-1:0]  cz_i,
  input  logic [tefr_pkg::RC_W-1:0]       read_col_i,
  input  logic [tefr_pkg::RC_W-1:0]       read_row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [tefr_pkg::XW-1:0]  depth_value_o,
  output logic                            cell_empty_o,
  output logic [tefr_pkg::OCNT_W-1:0]     cells_written_o
);
  import tefr_pkg::*;

  cmd_t ctrl_cmd;
  st_t  dp_st;

  // sequencing
  tefr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .st_i       (dp_st),
    .cmd_o      (ctrl_cmd)
  );

  // arithmetic, grid memory and result register
  tefr_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .st_o            (dp_st),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .ax_i            (ax_i),
    .ay_i            (ay_i),
    .az_i            (az_i),
    .bx_i            (bx_i),
    .by_coord_i      (by_coord_i),
    .bz_i            (bz_i),
    .cx_i            (cx_i),
    .cy_i            (cy_i),
    .cz_i            (cz_i),
    .read_col_i      (read_col_i),
    .read_row_i      (read_row_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .depth_value_o   (depth_value_o),
    .cell_empty_o    (cell_empty_o),
    .cells_written_o (cells_written_o)
  );

  // a finished result never lands on one still waiting
  `TEFR_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, ctrl_cmd.out_load, !out_valid_o || !out_stall_i, "result overwritten")
  // no request is taken while the grid is being cleared
  `TEFR_ASSERT_IMP(a_clear_stall, clk_i, rst_ni, ctrl_cmd.clr_run, in_stall_o, "request during clearing pass")
  // an accepted read request reads the grid in the next cycle
  `TEFR_ASSERT_NXT(a_read_issue, clk_i, rst_ni, in_valid_i && !in_stall_o && mode_i, ctrl_cmd.rd_en, "read not issued")

endmodule

// ===== bench/tefr_rasterizer_checker.sv =====
// request/result checker for the triangle rasterizer: shadows the depth grid and config
// registers, predicts each result and compares it field by field; depends on tefr_pkg
`timescale 1ns / 1ps

module tefr_rasterizer_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tefr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tefr_pkg::XW-1:0]             cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                mode_i,
  input  logic signed [tefr_pkg::XW-1:0]      ax_i,
  input  logic signed [tefr_pkg::XW-1:0]      ay_i,
  input  logic signed [tefr_pkg::XW-1:0]      az_i,
  input  logic signed [tefr_pkg::XW-1:0]      bx_i,
  input  logic signed [tefr_pkg::XW-1:0]      by_coord_i,
  input  logic signed [tefr_pkg::XW-1:0]      bz_i,
  input  logic signed [tefr_pkg::XW-1:0]      cx_i,
  input  logic signed [tefr_pkg::XW-1:0]      cy_i,
  input  logic signed [tefr_pkg::XW-1:0]      cz_i,
  input  logic [tefr_pkg::RC_W-1:0]           read_col_i,
  input  logic [tefr_pkg::RC_W-1:0]           read_row_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [tefr_pkg::XW-1:0]      depth_value_i,
  input  logic                                cell_empty_i,
  input  logic [tefr_pkg::OCNT_W-1:0]         cells_written_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import tefr_pkg::*;

  localparam int GRID_ROWS = DEF_MAX_ROWS;
  localparam int GRID_COLS = DEF_MAX_COLS;

  typedef struct packed {
    logic signed [XW-1:0] depth;
    logic                 empty;
    logic [OCNT_W-1:0]    count;
  } cell_result_t;

  logic [XW-1:0]       depth_shadow [GRID_ROWS*GRID_COLS];
  bit                  covered_shadow [GRID_ROWS*GRID_COLS];
  logic signed [XW-1:0] org_x, org_y;
  logic [CW_W-1:0]     cell_w, cell_h;
  logic [NUSE_W-1:0]   ncols, nrows;
  cell_result_t        expected_q [$];

  // edge function at the 4x scaled sample point, with tolerance
  function automatic bit edge_passes(longint x0, longint y0, longint x1, longint y1,
                                     longint px4, longint py4);
    logic signed [127:0] dx, dy, qx, qy, tol, e;
    dx  = x1 - x0;
    dy  = y1 - y0;
    qx  = px4 - 4 * x0;
    qy  = py4 - 4 * y0;
    tol = EDGE_TOL;
    e   = dx * qy - dy * qx + tol;
    return !e[127];
  endfunction

  // truncating division into cells, clamped to the grid in use
  function automatic longint to_cell(longint v, longint org, longint size, longint n);
    longint q;
    q = (v - org) / size;
    if (q < 0) q = 0;
    if (q > n - 1) q = n - 1;
    return q;
  endfunction

  // walk the bounding box, update the shadow grid, return the covered count
  function automatic cell_result_t rasterize_triangle();
    longint xs [3], ys [3], zs [3];
    longint cw, ch, nc, nr, c0, c1, r0, r1, px4, py4, zmin, xmin, xmax, ymin, ymax;
    int unsigned count;
    cell_result_t res;
    xs = '{longint'(ax_i), longint'(bx_i), longint'(cx_i)};
    ys = '{longint'(ay_i), longint'(by_coord_i), longint'(cy_i)};
    zs = '{longint'(az_i), longint'(bz_i), longint'(cz_i)};
    cw = (cell_w == 0) ? 1 : longint'(cell_w);
    ch = (cell_h == 0) ? 1 : longint'(cell_h);
    nc = ncols;
    nr = nrows;
    if (nc < 1) nc = 1;
    if (nc > GRID_COLS) nc = GRID_COLS;
    if (nr < 1) nr = 1;
    if (nr > GRID_ROWS) nr = GRID_ROWS;
    zmin = zs[0]; xmin = xs[0]; xmax = xs[0]; ymin = ys[0]; ymax = ys[0];
    for (int i = 1; i < 3; i++) begin
      if (zs[i] < zmin) zmin = zs[i];
      if (xs[i] < xmin) xmin = xs[i];
      if (xs[i] > xmax) xmax = xs[i];
      if (ys[i] < ymin) ymin = ys[i];
      if (ys[i] > ymax) ymax = ys[i];
    end
    c0 = to_cell(xmin, org_x, cw, nc);
    c1 = to_cell(xmax, org_x, cw, nc);
    r0 = to_cell(ymin, org_y, ch, nr);
    r1 = to_cell(ymax, org_y, ch, nr);
    count = 0;
    for (longint r = r0; r <= r1; r++) begin
      py4 = longint'(org_y) * 4 + (4 * r + 1) * ch;
      for (longint c = c0; c <= c1; c++) begin
        px4 = longint'(org_x) * 4 + (4 * c + 1) * cw;
        if (edge_passes(xs[0], ys[0], xs[1], ys[1], px4, py4) &&
            edge_passes(xs[1], ys[1], xs[2], ys[2], px4, py4) &&
            edge_passes(xs[2], ys[2], xs[0], ys[0], px4, py4)) begin
          depth_shadow[r * GRID_COLS + c]   = zmin[XW-1:0];
          covered_shadow[r * GRID_COLS + c] = 1'b1;
          count++;
        end
      end
    end
    res.depth = '0;
    res.empty = 1'b0;
    res.count = count[OCNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count_o++;
  endtask

  // config shadow, prediction on request, compare on result
  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t want;
    int idx;
    if (!rst_ni) begin
      org_x  <= '0;
      org_y  <= '0;
      cell_w <= RST_CELL_SIZE;
      cell_h <= RST_CELL_SIZE;
      ncols  <= RST_IN_USE;
      nrows  <= RST_IN_USE;
      for (int i = 0; i < GRID_ROWS * GRID_COLS; i++) begin
        depth_shadow[i]   = EMPTY_DEPTH;
        covered_shadow[i] = 1'b0;
      end
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ORIGIN_X:    org_x  <= cfg_data_i;
          REG_ORIGIN_Y:    org_y  <= cfg_data_i;
          REG_CELL_WIDTH:  cell_w <= cfg_data_i[CW_W-1:0];
          REG_CELL_HEIGHT: cell_h <= cfg_data_i[CW_W-1:0];
          REG_COLS_IN_USE: ncols  <= cfg_data_i[NUSE_W-1:0];
          REG_ROWS_IN_USE: nrows  <= cfg_data_i[NUSE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i) begin
          idx = int'(read_row_i) * GRID_COLS + int'(read_col_i);
          want.depth = depth_shadow[idx];
          want.empty = !covered_shadow[idx];
          want.count = '0;
        end else begin
          want = rasterize_triangle();
        end
        expected_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t result with no request outstanding", $time);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (depth_value_i !== want.depth)
            report_mismatch("depth_value", longint'(depth_value_i), longint'(want.depth));
          if (cell_empty_i !== want.empty)
            report_mismatch("cell_empty", longint'(cell_empty_i), longint'(want.empty));
          if (cells_written_i !== want.count)
            report_mismatch("cells_written", longint'(cells_written_i), longint'(want.count));
        end
      end
      pending_o <= expected_q.size();
    end
  end

  initial fail_count_o = 0;

endmodule

// ===== bench/tb_triangle_edge_function_rasterizer_unit.sv =====
// stimulus and verdict for the triangle rasterizer: directed and random requests over
// several grid settings; depends on tefr_pkg, the block and tefr_rasterizer_checker
`timescale 1ns / 1ps

module tb_triangle_edge_function_rasterizer_unit;
  import tefr_pkg::*;

  localparam int ONE = 65536;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [XW-1:0]         cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i = 1'b0;
  logic signed [XW-1:0]  ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [XW-1:0]  bx_i = '0, by_coord_i = '0, bz_i = '0;
  logic signed [XW-1:0]  cx_i = '0, cy_i = '0, cz_i = '0;
  logic [RC_W-1:0]       read_col_i = '0, read_row_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [XW-1:0]  depth_value_o;
  logic                  cell_empty_o;
  logic [OCNT_W-1:0]     cells_written_o;
  int                    fail_count, pending;

  // stimulus-side copy of the grid setup, for shaping triangles
  longint org_x_now, org_y_now, cw_now, ch_now, ncol_now, nrow_now;
  int     tri_sent, read_sent, cfg_phases;

  triangle_edge_function_rasterizer_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .mode_i,
    .ax_i, .ay_i, .az_i, .bx_i, .by_coord_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .read_col_i, .read_row_i,
    .out_valid_o, .out_stall_i, .depth_value_o, .cell_empty_o, .cells_written_o
  );

  tefr_rasterizer_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i,
    .ax_i, .ay_i, .az_i, .bx_i, .by_coord_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .read_col_i, .read_row_i,
    .out_valid_i(out_valid_o), .out_stall_i, .depth_value_i(depth_value_o),
    .cell_empty_i(cell_empty_o), .cells_written_i(cells_written_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard limit on run length
  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

  // result side: varying stall density, rare bursts, one long hold-off
  initial begin
    int stall_pct, cyc;
    bit held;
    stall_pct = 0;
    cyc = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 256 == 0) begin
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          default: stall_pct = 60;
        endcase
      end
      if (!held && tri_sent + read_sent >= 150) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 499) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [XW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // full grid setup, block idle
  task automatic set_grid(logic [XW-1:0] ox, logic [XW-1:0] oy, logic [XW-1:0] cw,
                          logic [XW-1:0] ch, logic [XW-1:0] nc, logic [XW-1:0] nr);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
    write_reg(REG_COLS_IN_USE, nc);
    write_reg(REG_ROWS_IN_USE, nr);
    org_x_now = longint'(signed'(ox));
    org_y_now = longint'(signed'(oy));
    cw_now    = (cw[CW_W-1:0] == 0) ? 1 : longint'(cw[CW_W-1:0]);
    ch_now    = (ch[CW_W-1:0] == 0) ? 1 : longint'(ch[CW_W-1:0]);
    ncol_now  = nc[NUSE_W-1:0];
    nrow_now  = nr[NUSE_W-1:0];
    cfg_phases++;
  endtask

  // one request, held until accepted, then a random gap
  task automatic send_request(bit m, logic [XW-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2,
                              logic [RC_W-1:0] rc, logic [RC_W-1:0] rr);
    int gap, r;
    in_valid_i <= 1'b1;
    mode_i     <= m;
    ax_i <= x0; ay_i <= y0;       az_i <= z0;
    bx_i <= x1; by_coord_i <= y1; bz_i <= z1;
    cx_i <= x2; cy_i <= y2;       cz_i <= z2;
    read_col_i <= rc;
    read_row_i <= rr;
    do @(posedge clk_i); while (in_stall_o);
    if (m) read_sent++;
    else tri_sent++;
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_triangle(longint x0, y0, z0, x1, y1, z1, x2, y2, z2);
    send_request(1'b0, x0[XW-1:0], y0[XW-1:0], z0[XW-1:0], x1[XW-1:0], y1[XW-1:0],
                 z1[XW-1:0], x2[XW-1:0], y2[XW-1:0], z2[XW-1:0], '0, '0);
  endtask

  task automatic send_read(int col, int row);
    send_request(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, col[RC_W-1:0], row[RC_W-1:0]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // small triangle near a random cell, mostly counter-clockwise; sometimes raw noise
  task automatic random_triangle();
    longint ax, ay, bx, by, cx, cy, bcx, bcy, t;
    logic signed [127:0] area;
    if ($urandom_range(0, 9) == 0) begin
      send_triangle(longint'(signed'($urandom)), longint'(signed'($urandom)),
                    longint'(signed'($urandom)), longint'(signed'($urandom)),
                    longint'(signed'($urandom)), longint'(signed'($urandom)),
                    longint'(signed'($urandom)), longint'(signed'($urandom)),
                    longint'(signed'($urandom)));
      return;
    end
    bcx = org_x_now + (longint'($urandom_range(0, ncol_now + 1)) - 1) * cw_now;
    bcy = org_y_now + (longint'($urandom_range(0, nrow_now + 1)) - 1) * ch_now;
    ax = bcx + $urandom_range(0, 3) * cw_now + $urandom_range(0, 255);
    ay = bcy + $urandom_range(0, 3) * ch_now + $urandom_range(0, 255);
    bx = bcx + $urandom_range(0, 3) * cw_now + $urandom_range(0, 255);
    by = bcy + $urandom_range(0, 3) * ch_now + $urandom_range(0, 255);
    cx = bcx + $urandom_range(0, 3) * cw_now + $urandom_range(0, 255);
    cy = bcy + $urandom_range(0, 3) * ch_now + $urandom_range(0, 255);
    // keep the coordinates as the block will see them
    ax = longint'(signed'(ax[XW-1:0])); ay = longint'(signed'(ay[XW-1:0]));
    bx = longint'(signed'(bx[XW-1:0])); by = longint'(signed'(by[XW-1:0]));
    cx = longint'(signed'(cx[XW-1:0])); cy = longint'(signed'(cy[XW-1:0]));
    area = (128'(signed'(bx - ax)) * 128'(signed'(cy - ay))) -
           (128'(signed'(by - ay)) * 128'(signed'(cx - ax)));
    if (area < 0 && $urandom_range(0, 99) < 85) begin
      t = bx; bx = cx; cx = t;
      t = by; by = cy; cy = t;
    end
    send_triangle(ax, ay, longint'(signed'($urandom)), bx, by, longint'(signed'($urandom)),
                  cx, cy, longint'(signed'($urandom)));
  endtask

  // main sequence
  initial begin
    logic [XW-1:0] ox, oy, cw, ch;
    int pick;
    tri_sent = 0;
    read_sent = 0;
    cfg_phases = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_grid('0, '0, ONE, ONE, 64, 64);

    // directed: empty reads, winding, degenerate, out of grid, extremes, overwrite
    send_read(0, 0);
    send_read(63, 63);
    send_triangle(0, 0, 5 * ONE, 4 * ONE, 0, 3 * ONE, 0, 4 * ONE, 7 * ONE);
    send_read(0, 0);
    send_read(1, 2);
    send_triangle(0, 0, -ONE, 0, 4 * ONE, 2, 4 * ONE, 0, 9);
    send_triangle(3 * ONE, 3 * ONE, 1, 3 * ONE, 3 * ONE, 2, 3 * ONE, 3 * ONE, 3);
    send_triangle(0, ONE / 4, 4, 8 * ONE, ONE / 4, 4, 16 * ONE, ONE / 4, 4);
    send_triangle(-20 * ONE, -20 * ONE, 11, -10 * ONE, -20 * ONE, 12, -15 * ONE, -5 * ONE, 13);
    send_triangle(0, 0, 32'h7FFF_FFFF, 2 * ONE, 0, -longint'(32'h8000_0000), 0, 2 * ONE, 0);
    send_read(0, 0);
    send_triangle(-longint'(32'h8000_0000), -longint'(32'h8000_0000), 21,
                  longint'(32'h7FFF_FFFF), -longint'(32'h8000_0000), 22,
                  -longint'(32'h8000_0000), longint'(32'h7FFF_FFFF), 23);
    send_triangle(0, 0, 30, 200 * ONE, 0, 31, 0, 200 * ONE, 32);
    send_read(63, 0);
    send_read(0, 63);
    send_read(40, 40);
    wait_idle();

    // extremes: zero width, widest height, column and row counts out of range
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 0, 127);
    send_triangle(-longint'(32'h8000_0000), longint'(32'h7FFF_FFFF), 41,
                  -longint'(32'h8000_0000) + 8, longint'(32'h7FFF_FFFF), 42,
                  -longint'(32'h8000_0000), -longint'(32'h8000_0000), 43);
    send_triangle(0, 0, 44, 5, 0, 45, 0, 5, 46);
    send_read(0, 0);
    send_read(0, 63);
    wait_idle();
    set_grid(32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_FFFF, 32'd1, 127, 0);
    send_triangle(-longint'(ONE), 16 * ONE, 51, 0, 16 * ONE, 52, 0, 16 * ONE + 3, 53);
    send_read(1, 0);
    wait_idle();

    // random phases, each with its own grid setup
    for (int ph = 0; ph < 6; ph++) begin
      pick = $urandom_range(0, 5);
      cw = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 : (pick == 2) ? 32'd16 :
           (pick == 3) ? 32'h7FFF_FFFF : (pick == 4) ? $urandom : ONE / 2 + $urandom_range(0, ONE);
      pick = $urandom_range(0, 5);
      ch = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 : (pick == 2) ? 32'd300 :
           (pick == 3) ? 32'h7FFF_FFFF : (pick == 4) ? $urandom : ONE / 2 + $urandom_range(0, ONE);
      ox = ($urandom_range(0, 3) == 0) ? $urandom : 32'(signed'($urandom_range(0, 8)) - 4) * ONE;
      oy = ($urandom_range(0, 3) == 0) ? $urandom : 32'(signed'($urandom_range(0, 8)) - 4) * ONE;
      set_grid(ox, oy, cw, ch, $urandom_range(0, 127), $urandom_range(0, 127));
      for (int k = 0; k < 220; k++) begin
        if ($urandom_range(0, 99) < 35) send_read($urandom_range(0, 63), $urandom_range(0, 63));
        else random_triangle();
      end
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    $display("covered %0d triangle and %0d read requests across %0d grid setups",
             tri_sent, read_sent, cfg_phases);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
